>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and the character map of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_LENGTH = 2'd1,
        STATUS_BAD_CHAR   = 2'd2,
        STATUS_BAD_PAD    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       last_of_item;
        logic       end_of_text;
        status_t    status;
    } result_t;

    // results caused by one character, entry 0 first
    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     entry;
    } bundle_t;

    // bit 6 set: not in the alphabet
    function automatic logic [6:0] sextet_of(logic [7:0] c);
        logic [7:0] v;
        v = 8'd64;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = c - 8'h41;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = c - 8'h61 + 8'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30 + 8'd52;
        end
        else if (c == 8'h2B)
        begin
            v = 8'd62;
        end
        else if (c == 8'h2F)
        begin
            v = 8'd63;
        end
        return v[6:0];
    endfunction

endpackage

>>> hw/rtl/b64d_group_decode.sv
// ----------------------------------------------------------------------------
// b64d_group_decode
// character register, group state and single-pass decode into a result bundle
// ----------------------------------------------------------------------------
module b64d_group_decode
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           char_code,
    input  logic                 final_char,
    output logic                 busy,
    output b64d_pkg::bundle_t    bundle
);

    logic                 valid_reg;
    logic [7:0]           char_reg;
    logic                 final_reg;

    logic [1:0]           pos_reg,   pos_next;
    logic [17:0]          gath_reg,  gath_next;
    logic [1:0]           pad_reg,   pad_next;
    b64d_pkg::status_t    err_reg,   err_next;

    logic [6:0]           map;
    logic [5:0]           sx;
    logic [23:0]          triple;
    logic [1:0]           n;
    b64d_pkg::bundle_t    res;

    assign map  = b64d_pkg::sextet_of(char_reg);
    assign busy = valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= char_code;
            final_reg <= final_char;
        end
    end

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            gath_reg <= 18'd0;
            pad_reg  <= 2'd0;
            err_reg  <= b64d_pkg::STATUS_OK;
        end
        else if (valid_reg)
        begin
            pos_reg  <= pos_next;
            gath_reg <= gath_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        gath_next = gath_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        sx        = 6'd0;
        triple    = {gath_reg, 6'd0};
        n         = 2'd0;
        res       = '0;

        if (err_reg == b64d_pkg::STATUS_OK)
        begin
            if (char_reg == b64d_pkg::PAD_CHAR)
            begin
                if (pos_reg < 2'd2)
                begin
                    err_next = b64d_pkg::STATUS_BAD_PAD;
                end
                else
                begin
                    pad_next = pad_reg + 2'd1;
                end
            end
            else if (pad_reg != 2'd0)
            begin
                err_next = b64d_pkg::STATUS_BAD_PAD;
            end
            else if (map[6])
            begin
                err_next = b64d_pkg::STATUS_BAD_CHAR;
            end
            else
            begin
                sx = map[5:0];
            end

            if (err_next == b64d_pkg::STATUS_OK)
            begin
                if (pos_reg != 2'd3)
                begin
                    gath_next = {gath_reg[11:0], sx};
                    pos_next  = pos_reg + 2'd1;
                end
                else if (pad_next != 2'd0 && !final_reg)
                begin
                    err_next = b64d_pkg::STATUS_BAD_PAD;
                end
                else
                begin
                    triple = {gath_reg, sx};
                    // one pad drops the last byte, two drop the last two
                    n = (pad_next >= 2'd2) ? 2'd1 : 2'd3 - pad_next;
                    for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
                    begin
                        res.entry[k].byte_value = triple[23-8*k -: 8];
                        res.entry[k].byte_valid = (2'(k) < n);
                    end
                    pos_next  = 2'd0;
                    gath_next = 18'd0;
                    pad_next  = 2'd0;
                end
            end

            if (final_reg && err_next == b64d_pkg::STATUS_OK && pos_reg != 2'd3)
            begin
                err_next = b64d_pkg::STATUS_BAD_LENGTH;
            end
        end

        if (final_reg)
        begin
            if (err_next != b64d_pkg::STATUS_OK)
            begin
                res                      = '0;
                n                        = 2'd1;
                res.entry[0].last_of_item = 1'b1;
                res.entry[0].end_of_text  = 1'b1;
                res.entry[0].status       = err_next;
            end
            else if (n != 2'd0)
            begin
                res.entry[n-2'd1].last_of_item = 1'b1;
                res.entry[n-2'd1].end_of_text  = 1'b1;
            end
            pos_next  = 2'd0;
            gath_next = 18'd0;
            pad_next  = 2'd0;
            err_next  = b64d_pkg::STATUS_OK;
        end
        else if (n != 2'd0)
        begin
            res.entry[n-2'd1].last_of_item = 1'b1;
        end

        // unused entries carry no byte
        for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
        begin
            if (2'(k) >= n)
            begin
                res.entry[k] = '0;
            end
        end

        res.count = valid_reg ? n : 2'd0;
        bundle    = res;
    end

endmodule

>>> hw/rtl/b64d_result_queue.sv
// ----------------------------------------------------------------------------
// b64d_result_queue
// result queue: takes up to three results per cycle, gives one per transfer
// ----------------------------------------------------------------------------
module b64d_result_queue
#(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  b64d_pkg::bundle_t           bundle,
    input  logic                        result_stall,
    output logic                        result_valid,
    output b64d_pkg::result_t           head,
    output logic                        pop,
    output logic [$clog2(DEPTH+1)-1:0]  count
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int ADDR_W = $clog2(DEPTH + 3);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    b64d_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [PTR_W-1:0]   wr_addr [b64d_pkg::MAX_RESULTS];
    logic [ADDR_W-1:0]  sum;
    logic [ADDR_W-1:0]  rd_sum;

    assign result_valid = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    assign count        = count_reg;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
        begin
            sum = ADDR_W'(wr_ptr_reg) + ADDR_W'(k);
            if (sum >= ADDR_W'(DEPTH))
            begin
                sum = sum - ADDR_W'(DEPTH);
            end
            wr_addr[k] = sum[PTR_W-1:0];
        end

        sum = ADDR_W'(wr_ptr_reg) + ADDR_W'(bundle.count);
        if (sum >= ADDR_W'(DEPTH))
        begin
            sum = sum - ADDR_W'(DEPTH);
        end
        wr_ptr_next = sum[PTR_W-1:0];

        rd_sum = ADDR_W'(rd_ptr_reg) + ADDR_W'(pop);
        if (rd_sum >= ADDR_W'(DEPTH))
        begin
            rd_sum = rd_sum - ADDR_W'(DEPTH);
        end
        rd_ptr_next = rd_sum[PTR_W-1:0];

        count_next = count_reg + CNT_W'(bundle.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++)
        begin
            if (2'(k) < bundle.count)
            begin
                mem_reg[wr_addr[k]] <= bundle.entry[k];
            end
        end
    end

endmodule

>>> hw/rtl/base64_stream_decoder.sv
// a character taken is held in the decode register, and its results are then
//   written into the result queue, from which they are transferred
// throughput: one character per cycle unless stalled, one result per cycle unless
//   stalled; a full group of four characters yields three results, which the result queue absorbs
// reset: rst_n clears the group state, the pending error and the queue at once
// ----------------------------------------------------------------------------
// base64_stream_decoder
// base64 text decoder, one character per transfer, up to three bytes per group
// ----------------------------------------------------------------------------
module base64_stream_decoder
#(
    // result queue depth, at least 6
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    // character channel
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        final_char,

    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  byte_value,
    output logic        byte_valid,
    output logic        last_of_item,
    output logic        end_of_text,
    output logic [1:0]  status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = $clog2(QUEUE_DEPTH + 8);

    logic                 accept;
    logic                 busy;
    logic                 pop;
    logic [CNT_W-1:0]     count;
    logic [SUM_W-1:0]     need;
    logic [SUM_W-1:0]     room;
    b64d_pkg::bundle_t    bundle;
    b64d_pkg::result_t    head;

    // a character in the decode register may push three results on the
    // next edge, and a new character may push three more after it has passed
    // the decode register; take a character only when both fit after this cycle's pop
    assign need       = SUM_W'(count) + (busy ? SUM_W'(3) : SUM_W'(0)) + SUM_W'(3);
    assign room       = SUM_W'(QUEUE_DEPTH) + SUM_W'(pop);
    assign char_stall = (need > room);
    assign accept     = char_valid && !char_stall;

    // decode stage: character register, group state, result bundle
    b64d_group_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_code  (char_code),
        .final_char (final_char),
        .busy       (busy),
        .bundle     (bundle)
    );

    // result queue, one result per transfer
    b64d_result_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle       (bundle),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .head         (head),
        .pop          (pop),
        .count        (count)
    );

    assign byte_value   = head.byte_value;
    assign byte_valid   = head.byte_valid;
    assign last_of_item = head.last_of_item;
    assign end_of_text  = head.end_of_text;
    assign status       = head.status;

endmodule
